// ===== sv/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants of the wavetable sound and IRQ unit.
// ----------------------------------------------------------------------------
package wts_pkg;

    localparam int RamDepth = 128;
    localparam int RamAw    = 7;
    localparam int ChW      = 3;
    localparam int PhW      = 21;

    localparam logic [PhW-1:0]   PhaseLimit = 21'h0F0000;
    localparam logic [14:0]      CountTop   = 15'h7FFF;
    localparam logic [RamAw-1:0] CntAddr    = 7'h7F;

    localparam logic [2:0] OFS_FREQ_LO  = 3'd0;
    localparam logic [2:0] OFS_FREQ_MID = 3'd2;
    localparam logic [2:0] OFS_CTRL     = 3'd4;
    localparam logic [2:0] OFS_WAVE     = 3'd6;
    localparam logic [2:0] OFS_VOL      = 3'd7;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        SEL_DATA   = 2'd0,
        SEL_CNT_LO = 2'd1,
        SEL_CNT_HI = 2'd2,
        SEL_ADDR   = 2'd3
    } t_sel;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] reg_sel;
        logic [7:0] wdata;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        rdata;
        logic signed [7:0] sample;
        logic              irq;
    } t_out_item;

    typedef struct packed {
        logic [7:0] freq_lo;
        logic [7:0] freq_mid;
        logic [4:0] ctrl;
        logic [7:0] wave;
        logic [3:0] vol;
    } t_chan_par;

    typedef struct packed {
        logic [ChW-1:0]   samp_idx;
        logic [ChW-1:0]   adv_ch;
        logic             ovf;
        logic [3:0]       vol;
        logic             nib_hi;
        logic [RamAw-1:0] wave_addr;
    } t_tick_info;

    typedef struct packed {
        logic       is_tick;
        logic       is_ram_rd;
        logic [7:0] rd_byte;
        logic       irq;
        t_tick_info tick;
    } t_stage;

endpackage

// ===== sv/wts_sram.sv =====
// ----------------------------------------------------------------------------
// wts_sram
// Sound RAM with address port, auto-increment and channel register shadows.
// ----------------------------------------------------------------------------
module wts_sram #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_acc,
    input  wts_pkg::t_in_item        i_item,
    input  logic [wts_pkg::RamAw-1:0] i_wave_addr,
    input  logic [wts_pkg::ChW-1:0]  i_ch,
    output wts_pkg::t_chan_par       o_par,
    output logic [2:0]               o_cnt,
    output logic [7:0]               o_rd_data
);
    import wts_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [7:0]          r_mem [RamDepth];
    logic [RamDepth-1:0] r_ram_vld;
    logic [7:0]          r_rd_byte;
    logic                r_rd_vld;
    logic [RamAw-1:0]    r_port_addr;
    logic                r_autoinc;
    logic [2:0]          r_cnt;
    t_chan_par           r_par [NUM_CHANNELS];

    logic             data_acc;
    logic             we;
    logic             re;
    logic [RamAw-1:0] raddr;
    logic [2:0]       sh_ch;
    logic             sh_hit;

    always_comb begin
        data_acc = i_acc && (i_item.reg_sel == SEL_DATA) &&
                   ((i_item.cmd == CMD_WRITE) || (i_item.cmd == CMD_READ));
        we       = data_acc && (i_item.cmd == CMD_WRITE);
        re       = i_acc && ((i_item.cmd == CMD_TICK) ||
                   ((i_item.cmd == CMD_READ) && (i_item.reg_sel == SEL_DATA)));
        raddr    = (i_item.cmd == CMD_TICK) ? i_wave_addr : r_port_addr;
        sh_ch    = ~r_port_addr[5:3];
        sh_hit   = r_port_addr[6] && ({1'b0, sh_ch} < 4'(NUM_CHANNELS));
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_port_addr] <= i_item.wdata;
        end
        if (re) begin
            r_rd_byte <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_port_addr <= '0;
            r_autoinc   <= 1'b0;
            r_cnt       <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_par[i] <= '0;
            end
        end else begin
            if (re) begin
                r_rd_vld <= r_ram_vld[raddr];
            end
            if (data_acc && r_autoinc) begin
                r_port_addr <= r_port_addr + 1'b1;
            end
            if (i_acc && (i_item.cmd == CMD_WRITE) && (i_item.reg_sel == SEL_ADDR)) begin
                r_autoinc   <= i_item.wdata[7];
                r_port_addr <= i_item.wdata[RamAw-1:0];
            end
            if (we) begin
                r_ram_vld[r_port_addr] <= 1'b1;
                if (r_port_addr == CntAddr) begin
                    r_cnt <= i_item.wdata[6:4];
                end
                if (sh_hit) begin
                    case (r_port_addr[2:0])
                        OFS_FREQ_LO:  r_par[sh_ch[CW-1:0]].freq_lo  <= i_item.wdata;
                        OFS_FREQ_MID: r_par[sh_ch[CW-1:0]].freq_mid <= i_item.wdata;
                        OFS_CTRL:     r_par[sh_ch[CW-1:0]].ctrl     <= i_item.wdata[4:0];
                        OFS_WAVE:     r_par[sh_ch[CW-1:0]].wave     <= i_item.wdata;
                        OFS_VOL:      r_par[sh_ch[CW-1:0]].vol      <= i_item.wdata[3:0];
                        default: ;
                    endcase
                end
            end
        end
    end

    assign o_par     = r_par[i_ch[CW-1:0]];
    assign o_cnt     = r_cnt;
    assign o_rd_data = r_rd_vld ? r_rd_byte : 8'h00;

endmodule

// ===== sv/wts_voice.sv =====
// ----------------------------------------------------------------------------
// wts_voice
// Channel sequencer: picks the next active channel and steps its phase and
// wave position.
// ----------------------------------------------------------------------------
module wts_voice #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_acc,
    input  logic                    i_tick,
    input  logic [2:0]              i_cnt,
    input  wts_pkg::t_chan_par      i_par,
    output logic [wts_pkg::ChW-1:0] o_ch,
    output wts_pkg::t_tick_info     o_tick
);
    import wts_pkg::*;

    localparam int         CW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [3:0] LastCh = 4'(NUM_CHANNELS - 1);

    logic [PhW-1:0] r_phase [NUM_CHANNELS];
    logic [5:0]     r_steps [NUM_CHANNELS];
    logic [7:0]     r_wpos  [NUM_CHANNELS];
    logic [ChW-1:0] r_out_idx;

    logic [3:0]     active;
    logic [3:0]     nxt;
    logic [ChW-1:0] ch;
    logic [PhW-1:0] sum;
    logic           ovf;
    logic [PhW-1:0] n_phase;
    logic [5:0]     n_steps;
    logic [7:0]     n_wpos;

    always_comb begin
        active = ({1'b0, i_cnt} > LastCh) ? LastCh : {1'b0, i_cnt};
        nxt    = {1'b0, r_out_idx} + 4'd1;
        if (nxt > active) begin
            nxt = 4'd0;
        end
        ch      = nxt[ChW-1:0];
        sum     = r_phase[ch[CW-1:0]] + PhW'({i_par.ctrl[1:0], i_par.freq_mid, i_par.freq_lo});
        ovf     = sum > PhaseLimit;
        n_phase = ovf ? (sum - PhaseLimit) : sum;
        n_steps = r_steps[ch[CW-1:0]];
        n_wpos  = r_wpos[ch[CW-1:0]];
        if (ovf) begin
            if (r_steps[ch[CW-1:0]] <= 6'd1) begin
                n_wpos  = i_par.wave;
                n_steps = 6'd32 - {1'b0, i_par.ctrl[4:2], 2'b00};
            end else begin
                n_steps = r_steps[ch[CW-1:0]] - 6'd1;
                n_wpos  = r_wpos[ch[CW-1:0]] + 8'd1;
            end
        end
        o_ch             = ch;
        o_tick.samp_idx  = r_out_idx;
        o_tick.adv_ch    = ch;
        o_tick.ovf       = ovf;
        o_tick.vol       = i_par.vol;
        o_tick.nib_hi    = n_wpos[0];
        o_tick.wave_addr = n_wpos[7:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_idx <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_phase[i] <= '0;
                r_steps[i] <= '0;
                r_wpos[i]  <= '0;
            end
        end else if (i_acc && i_tick) begin
            r_out_idx           <= ch;
            r_phase[ch[CW-1:0]] <= n_phase;
            r_steps[ch[CW-1:0]] <= n_steps;
            r_wpos[ch[CW-1:0]]  <= n_wpos;
        end
    end

endmodule

// ===== sv/wts_irq.sv =====
// ----------------------------------------------------------------------------
// wts_irq
// 15-bit saturating tick counter with enable and interrupt flag.
// ----------------------------------------------------------------------------
module wts_irq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  wts_pkg::t_in_item i_item,
    output logic [7:0]        o_rd_byte,
    output logic              o_irq_next
);
    import wts_pkg::*;

    logic [14:0] r_count;
    logic        r_enable;
    logic        r_flag;

    logic [14:0] n_count;
    logic        n_enable;
    logic        n_flag;
    logic        cnt_sel;

    always_comb begin
        n_count   = r_count;
        n_enable  = r_enable;
        n_flag    = r_flag;
        o_rd_byte = 8'h00;
        cnt_sel   = (i_item.reg_sel == SEL_CNT_LO) || (i_item.reg_sel == SEL_CNT_HI);
        case (i_item.cmd)
            CMD_TICK: begin
                if (r_enable && (r_count != CountTop)) begin
                    n_count = r_count + 15'd1;
                    if (n_count == CountTop) begin
                        n_flag = 1'b1;
                    end
                end
            end
            CMD_WRITE: begin
                if (cnt_sel) begin
                    n_flag = 1'b0;
                end
                if (i_item.reg_sel == SEL_CNT_LO) begin
                    n_count[7:0] = i_item.wdata;
                end else if (i_item.reg_sel == SEL_CNT_HI) begin
                    n_enable      = i_item.wdata[7];
                    n_count[14:8] = i_item.wdata[6:0];
                end
            end
            CMD_READ: begin
                if (cnt_sel) begin
                    n_flag = 1'b0;
                end
                if (i_item.reg_sel == SEL_CNT_LO) begin
                    o_rd_byte = r_count[7:0];
                end else if (i_item.reg_sel == SEL_CNT_HI) begin
                    o_rd_byte = {r_enable, r_count[14:8]};
                end
            end
            default: ;
        endcase
        o_irq_next = n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_enable <= 1'b0;
            r_flag   <= 1'b0;
        end else if (i_acc) begin
            r_count  <= n_count;
            r_enable <= n_enable;
            r_flag   <= n_flag;
        end
    end

endmodule

// ===== sv/wavetable_sound_irq_unit.sv =====
// ----------------------------------------------------------------------------
// wavetable_sound_irq_unit
// Eight-channel wavetable sound unit with IRQ counter, one bus access or
// CPU tick per transaction.
//
//   channel   direction   handshake            payload
//   item      in          i_valid / o_ready    i_item   (cmd, reg_sel, wdata)
//   result    out         o_valid / i_ready    o_result (rdata, sample, irq)
//
// One transaction per cycle while the result side does not stall; the accept
// updates state and issues the single sound RAM read, and the result register
// then forms the result from the registered RAM data. Reset clears the valid
// flags and state; the RAM has per-byte valid bits, so there is no clearing
// pass. A stalled result register holds the middle stage and lowers o_ready.
// ----------------------------------------------------------------------------
module wavetable_sound_irq_unit #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  wts_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output wts_pkg::t_out_item o_result
);
    import wts_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic              r_s1_vld;
    t_stage            r_s1;
    logic              r_o_vld;
    t_out_item         r_out;
    logic signed [7:0] r_level [NUM_CHANNELS];

    logic              in_acc;
    logic              s1_adv;
    logic              is_tick;
    logic [ChW-1:0]    ch;
    t_chan_par         par;
    logic [2:0]        cnt;
    t_tick_info        tick;
    logic [7:0]        ram_data;
    logic [7:0]        irq_byte;
    logic              irq_next;
    logic [3:0]        nib;
    logic signed [4:0] nib_s;
    logic signed [9:0] prod;
    t_out_item         n_out;
    t_stage            n_s1;

    assign s1_adv  = r_s1_vld && (!r_o_vld || i_ready);
    assign o_ready = !r_s1_vld || s1_adv;
    assign in_acc  = i_valid && o_ready;
    assign is_tick = (i_item.cmd == CMD_TICK);

    wts_sram #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_sram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (in_acc),
        .i_item     (i_item),
        .i_wave_addr(tick.wave_addr),
        .i_ch       (ch),
        .o_par      (par),
        .o_cnt      (cnt),
        .o_rd_data  (ram_data)
    );

    wts_voice #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_voice (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_acc  (in_acc),
        .i_tick (is_tick),
        .i_cnt  (cnt),
        .i_par  (par),
        .o_ch   (ch),
        .o_tick (tick)
    );

    wts_irq u_irq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (in_acc),
        .i_item    (i_item),
        .o_rd_byte (irq_byte),
        .o_irq_next(irq_next)
    );

    always_comb begin
        n_s1.is_tick   = is_tick;
        n_s1.is_ram_rd = (i_item.cmd == CMD_READ) && (i_item.reg_sel == SEL_DATA);
        n_s1.rd_byte   = irq_byte;
        n_s1.irq       = irq_next;
        n_s1.tick      = tick;

        nib   = r_s1.tick.nib_hi ? ram_data[7:4] : ram_data[3:0];
        nib_s = $signed({1'b0, nib}) - 5'sd8;
        prod  = $signed({1'b0, r_s1.tick.vol}) * nib_s;

        n_out.rdata  = r_s1.is_ram_rd ? ram_data : r_s1.rd_byte;
        n_out.sample = r_s1.is_tick ? r_level[r_s1.tick.samp_idx[CW-1:0]] : 8'sd0;
        n_out.irq    = r_s1.irq;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_level[i] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
            if (s1_adv && r_s1.is_tick && r_s1.tick.ovf) begin
                r_level[r_s1.tick.adv_ch[CW-1:0]] <= prod[7:0];
            end
        end
    end

    assign o_valid  = r_o_vld;
    assign o_result = r_out;

endmodule

// ===== sim/wts_sound_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wts_sound_checker
// Watches the item and result channels of the wavetable sound and IRQ unit.
// Every accepted bus transaction is run through a local copy of the sound
// RAM, voice state and IRQ counter to get its expected response. Each
// accepted result is compared in order, field by field, against the oldest
// pending response.
// ----------------------------------------------------------------------------
module wts_sound_checker #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  wts_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  wts_pkg::t_out_item i_out_result,
    output int                 o_err_count,
    output int                 o_pending
);
    import wts_pkg::*;

    localparam logic [RamAw-1:0] VoiceBaseTop = 7'h78;
    localparam logic [7:0]       LenMask      = 8'h1C;
    localparam int               WaveLenMax   = 32;

    logic [7:0]       snd_ram  [RamDepth];
    logic [PhW-1:0]   phase    [8];
    logic [5:0]       steps    [8];
    logic [7:0]       wave_pos [8];
    logic [7:0]       level    [8];
    logic [ChW-1:0]   out_ch;
    logic [14:0]      irq_cnt;
    logic             irq_en;
    logic             irq_q;
    logic [RamAw-1:0] port_addr;
    logic             port_inc;
    t_out_item        response_q [$];

    function automatic void clear_state();
        for (int i = 0; i < RamDepth; i++) snd_ram[i] = '0;
        for (int c = 0; c < 8; c++) begin
            phase[c]    = '0;
            steps[c]    = '0;
            wave_pos[c] = '0;
            level[c]    = '0;
        end
        out_ch    = '0;
        irq_cnt   = '0;
        irq_en    = 1'b0;
        irq_q     = 1'b0;
        port_addr = '0;
        port_inc  = 1'b0;
    endfunction

    function automatic void advance_voice(input int ch);
        logic [RamAw-1:0] base;
        logic [17:0]      freq;
        logic [PhW-1:0]   ph;
        logic [7:0]       wbyte;
        logic [3:0]       nib;
        logic [3:0]       vol;
        int               lv;
        base = VoiceBaseTop - RamAw'(8 * ch);
        freq = {snd_ram[base + OFS_CTRL][1:0], snd_ram[base + OFS_FREQ_MID],
                snd_ram[base + OFS_FREQ_LO]};
        ph = phase[ch] + freq;
        if (ph > PhaseLimit) begin
            vol = snd_ram[base + OFS_VOL][3:0];
            if (steps[ch] <= 6'd1) begin
                wave_pos[ch] = snd_ram[base + OFS_WAVE];
                steps[ch]    = 6'(WaveLenMax - int'(snd_ram[base + OFS_CTRL] & LenMask));
            end else begin
                steps[ch]    = steps[ch] - 6'd1;
                wave_pos[ch] = wave_pos[ch] + 8'd1;
            end
            ph        = ph - PhaseLimit;
            wbyte     = snd_ram[wave_pos[ch][7:1]];
            nib       = wave_pos[ch][0] ? wbyte[7:4] : wbyte[3:0];
            lv        = int'(vol) * (int'(nib) - 8);
            level[ch] = lv[7:0];
        end
        phase[ch] = ph;
    endfunction

    function automatic t_out_item bus_op_response(input t_in_item op);
        t_out_item r;
        int        act;
        int        nxt;
        r = '0;
        case (op.cmd)
            CMD_TICK: begin
                act = int'(snd_ram[CntAddr][6:4]);
                if (act > NUM_CHANNELS - 1) act = NUM_CHANNELS - 1;
                r.sample = level[out_ch];
                nxt = int'(out_ch) + 1;
                if (nxt > act) nxt = 0;
                out_ch = nxt[ChW-1:0];
                advance_voice(nxt);
                if (irq_en && irq_cnt != CountTop) begin
                    irq_cnt = irq_cnt + 15'd1;
                    if (irq_cnt == CountTop) irq_q = 1'b1;
                end
            end
            CMD_WRITE: begin
                case (op.reg_sel)
                    SEL_DATA: begin
                        snd_ram[port_addr] = op.wdata;
                        if (port_inc) port_addr = port_addr + 1'b1;
                    end
                    SEL_CNT_LO: begin
                        irq_q        = 1'b0;
                        irq_cnt[7:0] = op.wdata;
                    end
                    SEL_CNT_HI: begin
                        irq_q         = 1'b0;
                        irq_en        = op.wdata[7];
                        irq_cnt[14:8] = op.wdata[6:0];
                    end
                    default: begin
                        port_inc  = op.wdata[7];
                        port_addr = op.wdata[6:0];
                    end
                endcase
            end
            CMD_READ: begin
                case (op.reg_sel)
                    SEL_DATA: begin
                        r.rdata = snd_ram[port_addr];
                        if (port_inc) port_addr = port_addr + 1'b1;
                    end
                    SEL_CNT_LO: begin
                        irq_q   = 1'b0;
                        r.rdata = irq_cnt[7:0];
                    end
                    SEL_CNT_HI: begin
                        irq_q   = 1'b0;
                        r.rdata = {irq_en, irq_cnt[14:8]};
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        r.irq = irq_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_state();
            response_q.delete();
            o_err_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (response_q.size() == 0) begin
                    $error("result transaction with no pending response");
                    o_err_count++;
                end else begin
                    want = response_q.pop_front();
                    if (i_out_result.rdata !== want.rdata) begin
                        $error("rdata: expected %0h, actual %0h",
                               want.rdata, i_out_result.rdata);
                        o_err_count++;
                    end
                    if (i_out_result.sample !== want.sample) begin
                        $error("sample: expected %0d, actual %0d",
                               $signed(want.sample), $signed(i_out_result.sample));
                        o_err_count++;
                    end
                    if (i_out_result.irq !== want.irq) begin
                        $error("irq: expected %0b, actual %0b",
                               want.irq, i_out_result.irq);
                        o_err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) response_q.push_back(bus_op_response(i_in_item));
        end
        o_pending = response_q.size();
    end

endmodule

// ===== sim/tb_wavetable_sound_irq_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wavetable_sound_irq_unit
// Drives the wavetable sound and IRQ unit with a short directed run of bus
// transactions and ticks, then random voice programming, wave fills, tick
// bursts, counter runs, RAM reads and noise, with bursty input and a stalling sink.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_wavetable_sound_irq_unit;
    import wts_pkg::*;

    localparam int NumCh       = 8;
    localparam int RandOps     = 530;
    localparam int VoiceTop    = 'h78;
    localparam int StallLimit  = 2000;
    localparam int DrainCycles = 8;
    localparam int HoldOffAt   = 150;
    localparam int HoldOffLen  = 60;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_result;
    int        err_count;
    int        pending;
    t_in_item  bus_q [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    wavetable_sound_irq_unit #(
        .NUM_CHANNELS(NumCh)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_result(out_result)
    );

    wts_sound_checker #(
        .NUM_CHANNELS(NumCh)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_result(out_result),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    function automatic void put(input logic [1:0] op, input logic [1:0] sel,
                                input logic [7:0] data);
        t_in_item it;
        it.cmd     = op;
        it.reg_sel = sel;
        it.wdata   = data;
        bus_q.push_back(it);
    endfunction

    initial begin : stimulus
        int         kind;
        int         n;
        int         ch;
        int         k;
        int         n_dir;
        int         gap;
        int         burst_left;
        logic [7:0] b;

        put(CMD_READ, SEL_ADDR, 8'hFF);
        put(CMD_NOP, SEL_CNT_HI, 8'hFF);
        put(CMD_TICK, SEL_DATA, 8'h00);
        // voice 0: top frequency, 4-step wave at 0xFE, one channel, full volume
        put(CMD_WRITE, SEL_ADDR, 8'hF8);
        put(CMD_WRITE, SEL_DATA, 8'hFF);
        put(CMD_WRITE, SEL_DATA, 8'h00);
        put(CMD_WRITE, SEL_DATA, 8'hFF);
        put(CMD_WRITE, SEL_DATA, 8'h00);
        put(CMD_WRITE, SEL_DATA, 8'h1F);
        put(CMD_WRITE, SEL_DATA, 8'h00);
        put(CMD_WRITE, SEL_DATA, 8'hFE);
        put(CMD_WRITE, SEL_DATA, 8'h0F);
        put(CMD_WRITE, SEL_DATA, 8'h0F);
        put(CMD_WRITE, SEL_ADDR, 8'h7F);
        put(CMD_READ, SEL_DATA, 8'h00);
        put(CMD_WRITE, SEL_CNT_LO, 8'hFE);
        put(CMD_WRITE, SEL_CNT_HI, 8'hFF);
        repeat (10) put(CMD_TICK, SEL_DATA, 8'h00);
        put(CMD_READ, SEL_CNT_LO, 8'h00);
        put(CMD_READ, SEL_CNT_HI, 8'h00);
        n_dir = bus_q.size();

        while (bus_q.size() < n_dir + RandOps) begin
            kind = $urandom_range(0, 11);
            case (kind)
                0, 1: begin
                    ch = $urandom_range(0, 7);
                    put(CMD_WRITE, SEL_ADDR, {1'b1, 7'(VoiceTop - 8 * ch)});
                    for (k = 0; k < 8; k++) begin
                        b = 8'($urandom);
                        if (k == int'(OFS_CTRL) && $urandom_range(0, 3) != 0) b[1:0] = 2'b11;
                        put(CMD_WRITE, SEL_DATA, b);
                    end
                end
                2: begin
                    put(CMD_WRITE, SEL_ADDR, 8'($urandom));
                    n = $urandom_range(1, 8);
                    repeat (n) put(CMD_WRITE, SEL_DATA, 8'($urandom));
                end
                3, 4, 5, 6: begin
                    n = $urandom_range(4, 30);
                    repeat (n) put(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom));
                end
                7, 8: begin
                    put(CMD_WRITE, SEL_CNT_LO, ($urandom_range(0, 1) != 0) ?
                        8'($urandom_range(200, 255)) : 8'($urandom));
                    put(CMD_WRITE, SEL_CNT_HI, {1'($urandom_range(0, 3) != 0),
                        ($urandom_range(0, 2) != 0) ? 7'h7F : 7'($urandom)});
                    n = $urandom_range(2, 60);
                    repeat (n) begin
                        if ($urandom_range(0, 7) == 0) begin
                            put(CMD_READ, 2'($urandom_range(1, 2)), 8'($urandom));
                        end else begin
                            put(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom));
                        end
                    end
                end
                9, 10: begin
                    put(CMD_WRITE, SEL_ADDR, 8'($urandom));
                    n = $urandom_range(1, 6);
                    repeat (n) put(CMD_READ, SEL_DATA, 8'($urandom));
                end
                default: begin
                    n = $urandom_range(1, 4);
                    repeat (n) put(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                   8'($urandom));
                end
            endcase
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        foreach (bus_q[i]) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                gap = 0;
            end
            burst_left--;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_item  <= bus_q[i];
            do @(negedge clk); while (!in_ready);
            @(posedge clk);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // sink: random ready patterns plus one long hold-off to back up the pipe
    initial begin : result_sink
        int mode;
        int n;
        int cyc;
        bit held;
        cyc  = 0;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            mode = $urandom_range(0, 3);
            n    = $urandom_range(4, 40);
            repeat (n) begin
                if (!held && cyc >= HoldOffAt) begin
                    held = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HoldOffLen) @(posedge clk);
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 1) != 0);
                    default: out_ready <= (cyc % 4 != 3);
                endcase
                @(posedge clk);
                cyc++;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n);
        while (idle < StallLimit) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
